[hdl/sorted_priority_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent checks that drop out when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// check cons in the same cycle as ante
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sorted_priority_queue: same-cycle check failed");

// check cons in the cycle after ante
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sorted_priority_queue: next-cycle check failed");

`else

`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, status codes and the command bundle shared by the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FILL_W = 5;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [DATA_W-1:0] value;
	} spq_cmd_t;

endpackage

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the descending chain; keeps, takes the new item, or
// takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::spq_cmd_t                cmd,
	input  logic                             occ,
	input  logic                             prev_keep,
	input  logic signed [spq_pkg::DATA_W-1:0] prev_entry,
	input  logic signed [spq_pkg::DATA_W-1:0] next_entry,
	output logic                             keep,
	output logic signed [spq_pkg::DATA_W-1:0] entry
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] entry_q;

	assign keep  = occ && ($signed(entry_q) >= $signed(cmd.value));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.push) begin
			if (keep) begin
				entry_q <= entry_q;
			end else if (prev_keep) begin
				entry_q <= cmd.value;
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

endmodule

[hdl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// An accepted item's result lands in the output register on the next clock.
// Throughput: one item per cycle; a stalled result holds off the input.
// Reset clears the count and output valid; entries stay undefined until written.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic signed [spq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [spq_pkg::DATA_W-1:0] popped_value,
	output logic [1:0]                        status,
	output logic [spq_pkg::FILL_W-1:0]        fill_count
);
	import spq_pkg::*;

	logic                     accept;
	logic                     full;
	logic                     empty;
	spq_cmd_t                 cmd;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] popped_value_q;
	status_t                  status_q;
	logic [FILL_W-1:0]        fill_count_q;
	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic                     keep_w  [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	assign cmd.push  = accept && !req_type && !full;
	assign cmd.pop   = accept && req_type && !empty;
	assign cmd.value = value;

	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_keep_w;
		logic signed [DATA_W-1:0] prev_entry_w;
		logic signed [DATA_W-1:0] next_entry_w;

		if (i == 0) begin : g_first
			assign prev_keep_w  = 1'b1;
			assign prev_entry_w = '0;
		end else begin : g_mid
			assign prev_keep_w  = keep_w[i-1];
			assign prev_entry_w = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_entry_w = entry_w[i];
		end else begin : g_inner
			assign next_entry_w = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (CNT_W'(i) < count_q),
			.prev_keep  (prev_keep_w),
			.prev_entry (prev_entry_w),
			.next_entry (next_entry_w),
			.keep       (keep_w[i]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_value_q <= cmd.pop ? entry_w[0] : '0;
			fill_count_q   <= FILL_W'(count_d);
			if (!req_type && full) begin
				status_q <= ST_FULL;
			end else if (req_type && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_value_q;
	assign status       = status_q;
	assign fill_count   = fill_count_q;

	`SPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`SPQ_ASSERT_NEXT(a_full_drop, clk, arst_n, accept && !req_type && full, status_q == ST_FULL && $stable(count_q))
	`SPQ_ASSERT_NEXT(a_pop_count, clk, arst_n, cmd.pop, count_q == CNT_W'($past(count_q) - CNT_W'(1)))
	`SPQ_ASSERT_SAME(a_order, clk, arst_n, count_q >= CNT_W'(2), entry_w[0] >= entry_w[1])

endmodule
